>>> sv/frx_pkg.sv
// frx_pkg: shared types and constants for the frame receiver
// holds phase and status codes, field widths and default parameters
// no dependencies
package frx_pkg;

    localparam int FRX_FIFO_DEPTH = 256;
    localparam int BYTE_W         = 8;
    localparam int FILL_W         = 9;

    localparam logic [BYTE_W-1:0] FRAME_START_RESET = 8'd17;

    localparam logic KIND_LINK = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_LEN   = 2'd1,
        PH_DATA  = 2'd2,
        PH_SUM   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_GOOD     = 3'd1,
        ST_BADSTART = 3'd2,
        ST_CKFAIL   = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

endpackage

>>> sv/frame_receiver_with_fifo.sv
// frame_receiver_with_fifo: frame parser with sum-8 checksum and payload ring fifo
// depends on frx_pkg and frx_fifo_mem
//
// Link bytes (kind 0) walk a parser through start byte, length byte, length
// payload bytes and an additive 8-bit checksum over start, length and payload.
// Payload bytes are appended to a ring fifo held in a synchronous memory as they
// arrive; a full fifo drops the byte (status overflow) but the byte still counts
// toward the sum and the length. A wrong start byte is reported as bad start and
// parsing carries on. A checksum mismatch empties the whole fifo. Pop beats
// (kind 1) return the oldest byte; popping an empty fifo returns 0 with status
// empty pop. Every input beat yields exactly one result beat carrying data_out,
// status and the fill count after that beat. Throughput is one beat per clock
// unless out_ready stalls the output: parser state and pointers update in the
// accept cycle, and the single memory read port returns pop data in the cycle
// after. Results pass through the memory read stage and the output register.
// The memory is never cleared; a checksum fail just resets the pointers.
// frame_start is written with cfg_wr_en and takes effect on the next link beat.
module frame_receiver_with_fifo
    import frx_pkg::*;
#(
    parameter int FIFO_DEPTH = FRX_FIFO_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [BYTE_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [BYTE_W-1:0] byte_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] data_out,
    output logic [2:0]        status,
    output logic [FILL_W-1:0] fill_count
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    // configuration
    logic [BYTE_W-1:0] frame_start_reg;

    // parser and fifo control state
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] left_reg, left_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  held_reg, held_next;

    // decoded actions of the current beat
    status_t st_cur;
    logic    push;
    logic    pop_ok;
    logic    clear;

    // read stage: waits for memory read data
    logic              a_valid_reg;
    status_t           a_status_reg;
    logic [FILL_W-1:0] a_fill_reg;
    logic              a_pop_reg;

    // output register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] data_out_reg;
    status_t           out_status_reg;
    logic [FILL_W-1:0] out_fill_reg;

    logic              accept;
    logic              a_advance;
    logic [BYTE_W-1:0] rd_data;

    // read stage moves on when the output register is free or being drained
    assign a_advance = a_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !a_valid_reg || a_advance;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_start_reg <= FRAME_START_RESET;
        end
        else if (cfg_wr_en)
        begin
            frame_start_reg <= cfg_wr_data;
        end
    end

    // parser next state
    always_comb
    begin
        phase_next = phase_reg;
        if (kind == KIND_LINK)
        begin
            unique case (phase_reg)
                PH_START: phase_next = PH_LEN;
                PH_LEN:   phase_next = (byte_in != '0) ? PH_DATA : PH_SUM;
                PH_DATA:  phase_next = (left_reg == BYTE_W'(1)) ? PH_SUM : PH_DATA;
                PH_SUM:   phase_next = PH_START;
                default:  phase_next = PH_START;
            endcase
        end
    end

    // per-beat actions, status and datapath next values
    always_comb
    begin
        st_cur    = ST_OK;
        push      = 1'b0;
        pop_ok    = 1'b0;
        clear     = 1'b0;
        sum_next  = sum_reg;
        left_next = left_reg;
        if (kind == KIND_POP)
        begin
            if (held_reg == '0)
            begin
                st_cur = ST_EMPTY;
            end
            else
            begin
                pop_ok = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    sum_next = byte_in;
                    if (byte_in != frame_start_reg)
                    begin
                        st_cur = ST_BADSTART;
                    end
                end
                PH_LEN:
                begin
                    sum_next  = sum_reg + byte_in;
                    left_next = byte_in;
                end
                PH_DATA:
                begin
                    sum_next  = sum_reg + byte_in;
                    left_next = left_reg - BYTE_W'(1);
                    if (held_reg == CNT_FULL)
                    begin
                        st_cur = ST_OVERFLOW;
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
                PH_SUM:
                begin
                    if (sum_reg != byte_in)
                    begin
                        clear  = 1'b1;
                        st_cur = ST_CKFAIL;
                    end
                    else
                    begin
                        st_cur = ST_GOOD;
                    end
                end
                default:
                begin
                    st_cur = ST_OK;
                end
            endcase
        end
    end

    // fifo pointers and fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        held_next   = held_reg;
        if (clear)
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            held_next   = '0;
        end
        else if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            held_next   = held_reg + CNT_W'(1);
        end
        else if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            held_next   = held_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            left_reg   <= '0;
            sum_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            held_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            sum_reg    <= sum_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            held_reg   <= held_next;
        end
    end

    // a pop only reads entries pushed by an earlier beat, whose write has
    // already landed, so read and write never collide on one entry
    frx_fifo_mem #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (accept && push),
        .wr_addr (wr_ptr_reg),
        .wr_data (byte_in),
        .rd_en   (accept && pop_ok),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_advance)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_status_reg <= st_cur;
            a_fill_reg   <= FILL_W'(held_next);
            a_pop_reg    <= pop_ok;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (a_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_advance)
        begin
            data_out_reg   <= a_pop_reg ? rd_data : '0;
            out_status_reg <= a_status_reg;
            out_fill_reg   <= a_fill_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_out   = data_out_reg;
    assign status     = out_status_reg;
    assign fill_count = out_fill_reg;

    // fill never goes past the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_FULL)
        else $error("fifo fill exceeds depth");

    // an empty fifo has matching pointers
    assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pointers disagree with empty fill");

    // a memory read is only issued for a non-empty fifo
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pop_ok) |-> (held_reg != '0))
        else $error("read issued on empty fifo");

    // a stalled read stage keeps its beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !a_advance) |=> a_valid_reg)
        else $error("read stage beat lost");

    // a checksum fail always reports an empty fifo
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_CKFAIL)) |-> (out_fill_reg == '0))
        else $error("checksum fail with nonzero fill");

endmodule

>>> sv/frx_fifo_mem.sv
// frx_fifo_mem: payload byte store, one write port and one read port
// read data is registered
// depends on frx_pkg
module frx_fifo_mem
    import frx_pkg::*;
#(
    parameter int FIFO_DEPTH = FRX_FIFO_DEPTH,
    localparam int PTR_W     = $clog2(FIFO_DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [PTR_W-1:0]  wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [PTR_W-1:0]  rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [FIFO_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
